// ===== hw/rtl/qls_pkg.sv =====
// shared types, field codes and helpers for the quantized load/store unit
package qls_pkg;

  localparam int NumQuantRegs = 7;
  localparam logic [63:0] DoubleOne = 64'h3FF0_0000_0000_0000;

  typedef enum logic [2:0] {
    QT_FLOAT0 = 3'd0,
    QT_FLOAT1 = 3'd1,
    QT_FLOAT2 = 3'd2,
    QT_FLOAT3 = 3'd3,
    QT_U8     = 3'd4,
    QT_U16    = 3'd5,
    QT_S8     = 3'd6,
    QT_S16    = 3'd7
  } qtype_t;

  typedef struct packed {
    logic       is_store;
    qtype_t     qtype;
    logic [5:0] scale;
  } lane_ctrl_t;

  function automatic logic [3:0] elem_bytes(qtype_t t);
    logic [3:0] n;
    unique case (t)
      QT_U8, QT_S8:   n = 4'd1;
      QT_U16, QT_S16: n = 4'd2;
      default:        n = 4'd4;
    endcase
    return n;
  endfunction

endpackage

// ===== hw/rtl/qls_lane.sv =====
// one conversion lane: element to double on load, double to element on store
module qls_lane
  import qls_pkg::*;
(
  input  lane_ctrl_t  ctrl,
  input  logic [31:0] raw,
  input  logic [63:0] value,
  output logic [63:0] load_bits,
  output logic [31:0] store_elem
);

  // load side
  logic               l_neg;
  logic [15:0]        l_mag;
  logic [3:0]         l_msb;
  logic signed [12:0] l_exp;
  logic [67:0]        l_shift;
  logic [4:0]         f_msb;
  logic [4:0]         f_k;
  logic [22:0]        f_mant;
  logic [16:0]        l_sval;

  always_comb begin
    l_neg = 1'b0;
    l_sval = '0;
    l_mag = '0;
    unique case (ctrl.qtype)
      QT_U8:  l_mag = {8'd0, raw[7:0]};
      QT_U16: l_mag = raw[15:0];
      QT_S8: begin
        l_neg = raw[7];
        l_sval = {{9{raw[7]}}, raw[7:0]};
        l_mag = l_neg ? 16'(-l_sval) : l_sval[15:0];
      end
      QT_S16: begin
        l_neg = raw[15];
        l_sval = {raw[15], raw[15:0]};
        l_mag = l_neg ? 16'(-l_sval) : l_sval[15:0];
      end
      default: l_mag = '0;
    endcase
    l_msb = '0;
    for (int i = 0; i < 16; i++) begin
      if (l_mag[i]) l_msb = 4'(i);
    end
    l_exp = 13'sd1023 + $signed({9'd0, l_msb}) - $signed({{7{ctrl.scale[5]}}, ctrl.scale});
    l_shift = {52'd0, l_mag} << (7'd52 - {3'd0, l_msb});

    f_msb = '0;
    for (int i = 0; i < 23; i++) begin
      if (raw[i]) f_msb = 5'(i);
    end
    f_k = 5'd23 - f_msb;
    f_mant = 23'(raw[22:0] << f_k);

    if (ctrl.qtype == QT_U8 || ctrl.qtype == QT_U16 || ctrl.qtype == QT_S8 ||
        ctrl.qtype == QT_S16) begin
      if (l_mag == '0) load_bits = '0;
      else load_bits = {l_neg, l_exp[10:0], l_shift[51:0]};
    end else if (raw[30:23] == 8'hFF) begin
      load_bits = {raw[31], 11'h7FF, raw[22:0], 29'd0};
    end else if (raw[30:23] == 8'd0) begin
      if (raw[22:0] == '0) load_bits = {raw[31], 63'd0};
      else load_bits = {raw[31], 11'(11'd874 + {6'd0, f_msb}), f_mant, 29'd0};
    end else begin
      load_bits = {raw[31], 11'({3'd0, raw[30:23]} + 11'd896), raw[22:0], 29'd0};
    end
  end

  // store side
  logic               s_sign;
  logic [10:0]        s_e;
  logic [51:0]        s_m;
  logic [52:0]        s_sig;
  logic signed [12:0] s_fe;
  logic signed [12:0] s_extra;
  logic [5:0]         s_sh;
  logic [116:0]       s_full;
  logic [52:0]        s_q;
  logic               s_up;
  logic [24:0]        s_qr;
  logic signed [12:0] s_fe2;
  logic [31:0]        s_single;
  logic signed [12:0] i_e;
  logic [52:0]        i_shift;
  logic [16:0]        i_mag;
  logic [16:0]        i_lim;
  logic [31:0]        s_int;

  always_comb begin
    s_sign = value[63];
    s_e = value[62:52];
    s_m = value[51:0];
    s_sig = {1'b1, s_m};
    s_fe = $signed({2'd0, s_e}) - 13'sd896;
    s_extra = 13'sd1 - s_fe;
    s_sh = (s_fe <= 0 && s_extra <= 13'sd30) ? 6'(13'sd29 + s_extra) : 6'd29;
    s_full = {s_sig, 64'd0} >> s_sh;
    s_q = s_full[116:64];
    s_up = s_full[63] & ((|s_full[62:0]) | s_q[0]);
    s_qr = 25'(s_q) + {24'd0, s_up};
    s_fe2 = s_fe;
    if (s_qr[24]) begin
      s_qr = s_qr >> 1;
      s_fe2 = s_fe + 13'sd1;
    end
    if (s_e == 11'h7FF) begin
      if (s_m != '0) s_single = {s_sign, 8'hFF, 1'b1, s_m[50:29]};
      else s_single = {s_sign, 8'hFF, 23'd0};
    end else if (s_e == 11'd0) begin
      s_single = {s_sign, 31'd0};
    end else if (s_fe <= 0) begin
      if (s_extra > 13'sd30) s_single = {s_sign, 31'd0};
      else s_single = {s_sign, 31'(s_q)} + {31'd0, s_up};
    end else if (s_fe2 >= 13'sd255) begin
      s_single = {s_sign, 8'hFF, 23'd0};
    end else begin
      s_single = {s_sign, s_fe2[7:0], s_qr[22:0]};
    end

    i_e = $signed({2'd0, s_e}) - 13'sd1023 + $signed({{7{ctrl.scale[5]}}, ctrl.scale});
    i_shift = s_sig >> 6'(13'sd52 - i_e);
    if (s_e == 11'h7FF || i_e >= 13'sd16) i_mag = 17'h1FFFF;
    else if (s_e == 11'd0 || i_e < 0) i_mag = '0;
    else i_mag = i_shift[16:0];

    i_lim = '0;
    s_int = '0;
    if (!(s_e == 11'h7FF && s_m != '0)) begin
      unique case (ctrl.qtype)
        QT_U8: begin
          i_lim = (i_mag > 17'd255) ? 17'd255 : i_mag;
          s_int = s_sign ? 32'd0 : {24'd0, i_lim[7:0]};
        end
        QT_U16: begin
          i_lim = (i_mag > 17'd65535) ? 17'd65535 : i_mag;
          s_int = s_sign ? 32'd0 : {16'd0, i_lim[15:0]};
        end
        QT_S8: begin
          if (s_sign) begin
            i_lim = (i_mag > 17'd128) ? 17'd128 : i_mag;
            s_int = {24'd0, 8'(-i_lim)};
          end else begin
            i_lim = (i_mag > 17'd127) ? 17'd127 : i_mag;
            s_int = {24'd0, i_lim[7:0]};
          end
        end
        QT_S16: begin
          if (s_sign) begin
            i_lim = (i_mag > 17'd32768) ? 17'd32768 : i_mag;
            s_int = {16'd0, 16'(-i_lim)};
          end else begin
            i_lim = (i_mag > 17'd32767) ? 17'd32767 : i_mag;
            s_int = {16'd0, i_lim[15:0]};
          end
        end
        default: s_int = '0;
      endcase
    end

    store_elem = (ctrl.qtype == QT_U8 || ctrl.qtype == QT_U16 || ctrl.qtype == QT_S8 ||
                  ctrl.qtype == QT_S16) ? s_int : s_single;
  end

endmodule

// ===== hw/rtl/paired_single_quantized_load_store.sv =====
// top level: quantization registers, two conversion lanes and the merge/output stage
// an accepted request's result appears in the output register in the next cycle
// throughput: one request per cycle unless out_stall holds the output, set by the single output register stage
// the output register holds a valid result while out_stall is high and new requests then wait
// reset clears the quantization registers to zero and empties the output stage
module paired_single_quantized_load_store
  import qls_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [2:0]  quant_select,
  input  logic        single_flag,
  input  logic [31:0] address,
  input  logic [63:0] load_bytes,
  input  logic [63:0] store_value0,
  input  logic [63:0] store_value1,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] ps0_bits,
  output logic [63:0] ps1_bits,
  output logic [63:0] store_data,
  output logic [3:0]  store_length,
  output logic [31:0] store_address,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] quant_reg [NumQuantRegs];
  logic [31:0] gqr;
  lane_ctrl_t  ctrl;
  logic [3:0]  nbytes;
  logic [31:0] raw0, raw1;
  logic [63:0] ld0, ld1;
  logic [31:0] st0, st1;
  logic [63:0] pack;
  logic        take;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign take      = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumQuantRegs; i++) quant_reg[i] <= '0;
    end else if (cfg_valid && cfg_ready && cfg_index < 3'(NumQuantRegs)) begin
      quant_reg[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    gqr = (quant_select == 3'd0) ? 32'd0 : quant_reg[quant_select - 3'd1];
    ctrl.is_store = req_type;
    ctrl.qtype = req_type ? qtype_t'(gqr[2:0]) : qtype_t'(gqr[18:16]);
    ctrl.scale = req_type ? gqr[13:8] : gqr[29:24];
    nbytes = elem_bytes(ctrl.qtype);
    case (nbytes)
      4'd1: begin
        raw0 = {24'd0, load_bytes[63:56]};
        raw1 = {24'd0, load_bytes[55:48]};
      end
      4'd2: begin
        raw0 = {16'd0, load_bytes[63:48]};
        raw1 = {16'd0, load_bytes[47:32]};
      end
      default: begin
        raw0 = load_bytes[63:32];
        raw1 = load_bytes[31:0];
      end
    endcase
  end

  qls_lane u_lane0 (
    .ctrl(ctrl), .raw(raw0), .value(store_value0), .load_bits(ld0), .store_elem(st0)
  );

  qls_lane u_lane1 (
    .ctrl(ctrl), .raw(raw1), .value(store_value1), .load_bits(ld1), .store_elem(st1)
  );

  // merge the lanes into one packed store word
  always_comb begin
    case (nbytes)
      4'd1:    pack = {st0[7:0], single_flag ? 8'd0 : st1[7:0], 48'd0};
      4'd2:    pack = {st0[15:0], single_flag ? 16'd0 : st1[15:0], 32'd0};
      default: pack = {st0, single_flag ? 32'd0 : st1};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (req_type) begin
        ps0_bits      <= '0;
        ps1_bits      <= '0;
        store_data    <= pack;
        store_length  <= single_flag ? nbytes : 4'(nbytes << 1);
        store_address <= address;
      end else begin
        ps0_bits      <= ld0;
        ps1_bits      <= single_flag ? DoubleOne : ld1;
        store_data    <= '0;
        store_length  <= '0;
        store_address <= '0;
      end
    end
  end

  a_store_clears_load: assert property (@(posedge clk) disable iff (rst)
    out_valid && store_length != 4'd0 |-> ps0_bits == 64'd0 && ps1_bits == 64'd0)
    else $error("store result carries load values");

  a_length_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> store_length == 4'd0 || store_length == 4'd1 || store_length == 4'd2 ||
                  store_length == 4'd4 || store_length == 4'd8)
    else $error("illegal store length");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted request did not reach the output register");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

// ===== dv/tb_paired_single_quantized_load_store.sv =====
// self-checking testbench for the quantized load/store unit with its own conversion predictor
`timescale 1ns / 100ps

module tb_paired_single_quantized_load_store
  import qls_pkg::*;
();

  typedef struct packed {
    logic        req_type;
    logic [2:0]  quant_select;
    logic        single_flag;
    logic [31:0] address;
    logic [63:0] load_bytes;
    logic [63:0] store_value0;
    logic [63:0] store_value1;
  } access_t;

  typedef struct packed {
    logic [63:0] ps0_bits;
    logic [63:0] ps1_bits;
    logic [63:0] store_data;
    logic [3:0]  store_length;
    logic [31:0] store_address;
  } access_result_t;

  localparam int CycleLimit = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        req_type = 1'b0;
  logic [2:0]  quant_select = '0;
  logic        single_flag = 1'b0;
  logic [31:0] address = '0;
  logic [63:0] load_bytes = '0;
  logic [63:0] store_value0 = '0;
  logic [63:0] store_value1 = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] ps0_bits;
  logic [63:0] ps1_bits;
  logic [63:0] store_data;
  logic [3:0]  store_length;
  logic [31:0] store_address;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  access_t        pending_access[$];
  access_result_t expected_result[$];
  logic [31:0]    quant_model[NumQuantRegs];
  int             mismatches = 0;
  int             cycle_count = 0;
  bit             quiet_tail = 1'b0;
  bit             long_hold = 1'b0;
  int             send_gap = 0;
  int             recv_gap = 0;
  int             hold_count = 0;

  paired_single_quantized_load_store i_dut (.*);

  always #10 clk = ~clk;

  function automatic logic [63:0] pow2_bits(int n);
    return 64'(1023 + n) << 52;
  endfunction

  function automatic int scale_of(logic [5:0] s);
    return s[5] ? int'(s) - 64 : int'(s);
  endfunction

  function automatic logic [63:0] widen_single(logic [31:0] f);
    logic [63:0] m;
    int ex;
    m = {41'b0, f[22:0]};
    if (f[30:23] == 8'hFF) return {f[31], 11'h7FF, 52'(m << 29)};
    if (f[30:23] == 0) begin
      if (m == 0) return {f[31], 63'b0};
      ex = -126;
      while (!m[23]) begin
        m = m << 1;
        ex--;
      end
      m[23] = 1'b0;
    end else begin
      ex = int'(f[30:23]) - 127;
    end
    return {f[31], 11'(ex + 1023), 52'(m << 29)};
  endfunction

  function automatic logic [31:0] narrow_double(logic [63:0] d);
    logic [63:0] sig, q, rem, half;
    int fe, sh;
    if (d[62:52] == 11'h7FF) begin
      if (d[51:0] != 0) return {d[63], 31'h7FC00000 | 31'(d[51:29])};
      return {d[63], 31'h7F800000};
    end
    if (d[62:52] == 0) return {d[63], 31'b0};
    sig = {11'b1, d[51:0]};
    fe = int'(d[62:52]) - 1023 + 127;
    sh = 29;
    if (fe <= 0) begin
      if (1 - fe > 30) return {d[63], 31'b0};
      sh = 29 + 1 - fe;
    end
    q = sig >> sh;
    rem = sig & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q++;
    if (fe <= 0) return {d[63], 31'(q)};
    if (q[24]) begin
      q = q >> 1;
      fe++;
    end
    if (fe >= 255) return {d[63], 31'h7F800000};
    return {d[63], 8'(fe), q[22:0]};
  endfunction

  function automatic logic [63:0] dequant(logic [31:0] raw, qtype_t t, int sc);
    real v;
    case (t)
      QT_U8:   v = real'(raw[7:0]);
      QT_U16:  v = real'(raw[15:0]);
      QT_S8:   v = real'($signed(raw[7:0]));
      QT_S16:  v = real'($signed(raw[15:0]));
      default: return widen_single(raw);
    endcase
    return $realtobits(v * $bitstoreal(pow2_bits(-sc)));
  endfunction

  function automatic logic [31:0] quant(logic [63:0] vb, qtype_t t, int sc);
    real x, lo, hi;
    int r;
    if (t < QT_U8) return narrow_double(vb);
    x = $bitstoreal(vb) * $bitstoreal(pow2_bits(sc));
    if (x != x) return 0;
    case (t)
      QT_U8:   begin lo = 0.0;      hi = 255.0;   end
      QT_U16:  begin lo = 0.0;      hi = 65535.0; end
      QT_S8:   begin lo = -128.0;   hi = 127.0;   end
      default: begin lo = -32768.0; hi = 32767.0; end
    endcase
    if (x < lo) x = lo;
    if (x > hi) x = hi;
    r = $rtoi(x);
    return (t == QT_U8 || t == QT_S8) ? (32'(r) & 32'hFF) : (32'(r) & 32'hFFFF);
  endfunction

  function automatic access_result_t convert_access(access_t a);
    access_result_t r;
    logic [31:0] g;
    qtype_t t;
    int sc, sz;
    logic [63:0] mask;
    r = '0;
    g = (a.quant_select != 0) ? quant_model[a.quant_select - 1] : 32'd0;
    if (!a.req_type) begin
      t = qtype_t'(g[18:16]);
      sc = scale_of(g[29:24]);
      sz = int'(elem_bytes(t));
      mask = (sz == 4) ? 64'hFFFF_FFFF : ((64'd1 << (8 * sz)) - 1);
      r.ps0_bits = dequant(32'((a.load_bytes >> (64 - 8 * sz)) & mask), t, sc);
      r.ps1_bits = a.single_flag ? DoubleOne
                 : dequant(32'((a.load_bytes >> (64 - 16 * sz)) & mask), t, sc);
    end else begin
      t = qtype_t'(g[2:0]);
      sc = scale_of(g[13:8]);
      sz = int'(elem_bytes(t));
      r.store_data = 64'(quant(a.store_value0, t, sc)) << (64 - 8 * sz);
      r.store_length = 4'(sz);
      if (!a.single_flag) begin
        r.store_data |= 64'(quant(a.store_value1, t, sc)) << (64 - 16 * sz);
        r.store_length = 4'(2 * sz);
      end
      r.store_address = a.address;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    mismatches++;
  endtask

  // request driver
  always @(posedge clk) begin
    access_t a;
    if (!rst) begin
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_access.size() != 0) begin
          if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            send_gap <= $urandom_range(1, 6);
            in_valid <= 1'b0;
          end else begin
            a = pending_access.pop_front();
            expected_result.push_back(convert_access(a));
            in_valid <= 1'b1;
            req_type <= a.req_type;
            quant_select <= a.quant_select;
            single_flag <= a.single_flag;
            address <= a.address;
            load_bytes <= a.load_bytes;
            store_value0 <= a.store_value0;
            store_value1 <= a.store_value1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall control
  always @(posedge clk) begin
    if (!rst) begin
      if (long_hold) begin
        out_stall <= 1'b1;
        hold_count <= hold_count + 1;
      end else if (quiet_tail) begin
        out_stall <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        recv_gap <= $urandom_range(0, 5);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    access_result_t w;
    cycle_count <= cycle_count + 1;
    if (!rst && out_valid && !out_stall) begin
      if (expected_result.size() == 0) begin
        report_mismatch("unexpected result", ps0_bits, 0);
      end else begin
        w = expected_result.pop_front();
        if (ps0_bits !== w.ps0_bits) report_mismatch("ps0_bits", ps0_bits, w.ps0_bits);
        if (ps1_bits !== w.ps1_bits) report_mismatch("ps1_bits", ps1_bits, w.ps1_bits);
        if (store_data !== w.store_data) report_mismatch("store_data", store_data, w.store_data);
        if (store_length !== w.store_length)
          report_mismatch("store_length", 64'(store_length), 64'(w.store_length));
        if (store_address !== w.store_address)
          report_mismatch("store_address", 64'(store_address), 64'(w.store_address));
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_quant(int idx, logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= 3'(idx);
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    quant_model[idx] = v;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_access.size() != 0 || expected_result.size() != 0 || in_valid)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [63:0] random_double();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v[62:52] = 11'h7FF;
      1: v[62:52] = 11'(1023 + $urandom_range(0, 40) - 20);
      2: v[62:52] = 11'(897 - $urandom_range(0, 30));
      3: v[62:52] = 11'(1150 + $urandom_range(0, 10));
      4: v[62:52] = $urandom_range(0, 1) ? 11'h0 : 11'h7FF;
      default: ;
    endcase
    return v;
  endfunction

  function automatic access_t random_access();
    access_t a;
    a.req_type = $urandom_range(0, 1);
    a.quant_select = $urandom_range(0, 7);
    a.single_flag = $urandom_range(0, 1);
    a.address = $urandom;
    a.load_bytes = {$urandom, $urandom};
    a.store_value0 = random_double();
    a.store_value1 = random_double();
    return a;
  endfunction

  function automatic logic [31:0] random_quant();
    logic [31:0] v;
    v = $urandom;
    if ($urandom_range(0, 1)) v[13:8] = 6'($urandom_range(0, 8) - 4);
    if ($urandom_range(0, 1)) v[29:24] = 6'($urandom_range(0, 8) - 4);
    return v;
  endfunction

  initial begin
    access_t a;
    logic [63:0] edge_vals[8];
    int i;
    edge_vals = '{64'h0, 64'h8000_0000_0000_0000, 64'h7FF0_0000_0000_0000,
                  64'h7FF0_0000_0000_0001, 64'hFFF8_0000_0000_0000, 64'h47F0_0000_0000_0000,
                  64'h3690_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF};
    for (i = 0; i < NumQuantRegs; i++) quant_model[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // extremes of type and scale
    write_quant(0, 32'h0000_0000);
    write_quant(1, 32'h1F04_1F04);
    write_quant(2, 32'h2005_2005);
    write_quant(3, 32'h3F06_3F06);
    write_quant(4, 32'h0007_0007);
    write_quant(5, 32'hFFFF_FFFF);
    write_quant(6, 32'h0103_0103);
    for (i = 0; i < 24; i++) begin
      a.req_type = i[0];
      a.quant_select = 3'(i % 8);
      a.single_flag = i[1];
      a.address = (i < 12) ? 32'hFFFF_FFFF : 32'h0;
      a.load_bytes = (i < 8) ? {8{8'h80}} : (i < 16 ? 64'hFFFF_FFFF_FFFF_FFFF
                                                    : 64'h7F80_0001_0000_0001);
      a.store_value0 = edge_vals[i % 8];
      a.store_value1 = edge_vals[(i + 3) % 8];
      pending_access.push_back(a);
    end
    wait_drained();
    for (int phase = 0; phase < 4; phase++) begin
      for (i = 0; i < NumQuantRegs; i++) write_quant(i, random_quant());
      for (i = 0; i < 100; i++) pending_access.push_back(random_access());
      if (phase == 1) begin
        // long receiver hold while requests keep coming
        long_hold = 1'b1;
        while (hold_count < 40) @(posedge clk);
        long_hold = 1'b0;
      end
      if (phase == 3) quiet_tail = 1'b1;
      wait_drained();
    end
    for (i = 0; i < 30; i++) pending_access.push_back(random_access());
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_result.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
